// ----- hw/rtl/txc_pkg.sv -----
package txc_pkg;

	// Width of each field of a request and of a result.
	localparam int ACTION_W = 1;
	localparam int CHAR_W   = 8;
	localparam int ROW_W    = 5;
	localparam int COL_W    = 7;

	// Request actions.
	localparam logic [ACTION_W-1:0] ACT_PUT  = 1'b0;
	localparam logic [ACTION_W-1:0] ACT_READ = 1'b1;

	// Character codes with a meaning of their own.
	localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
	localparam logic [CHAR_W-1:0] NULL_CODE    = 8'd0;

	// One request on the input channel.
	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [CHAR_W-1:0]   char_code;
		logic [ROW_W-1:0]    read_row;
		logic [COL_W-1:0]    read_column;
	} req_t;

	// One result on the output channel.
	typedef struct packed {
		logic [CHAR_W-1:0] cell_char;
		logic [ROW_W-1:0]  cursor_row;
		logic [COL_W-1:0]  cursor_column;
		logic              scrolled;
		logic              dropped;
	} rsp_t;

endpackage

// ----- hw/rtl/txc_chan_if.sv -----
// Valid/ready channel carrying one payload word per request.
interface txc_chan_if #(
	parameter type payload_t = logic [7:0]
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- hw/rtl/text_console_cell_buffer_unit.sv -----
// Channel  Modport  Payload        Direction
// -------  -------  -------------  ---------
// req      sink     txc_pkg::req_t into the console
// rsp      source   txc_pkg::rsp_t out of the console
//
// A put or newline passes EXEC and DONE from acceptance to the result register, a read
// passes EXEC, READ and DONE, and a newline that scrolls passes EXEC, SWEEP and DONE;
// the sweep clears the recycled row one cell per cycle through the single memory port.
// Counting the idle state that accepts it, a put occupies IDLE, EXEC and DONE.
// After reset a clearing pass over all ROWS*COLUMNS cells zeroes the store first. A stalled
// result holds in the output register; the next request waits until it has moved there.
module text_console_cell_buffer_unit #(
	parameter int unsigned ROWS    = 25,
	parameter int unsigned COLUMNS = 80
) (
	input  logic clk,
	input  logic arst_n,
	txc_chan_if.sink   req,
	txc_chan_if.source rsp
);

	localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CW    = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int DEPTH = ROWS * COLUMNS;
	localparam int AW    = $clog2(DEPTH);

	typedef enum logic [5:0] {
		ST_INIT  = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_EXEC  = 6'b000100,
		ST_READ  = 6'b001000,
		ST_SWEEP = 6'b010000,
		ST_DONE  = 6'b100000
	} state_t;

	state_t          state_q;
	txc_pkg::req_t   item_q;
	txc_pkg::rsp_t   rsp_q;
	logic            rsp_valid_q;
	logic [RW-1:0]   row_q;
	logic [CW-1:0]   col_q;
	logic [RW-1:0]   base_q;
	logic [RW-1:0]   sweep_row_q;
	logic [CW-1:0]   sweep_col_q;
	logic [7:0]      cell_q;
	logic            scrolled_q;
	logic            dropped_q;
	logic            range_q;
	logic [7:0]      rd_data_q;
	logic [7:0]      mem [DEPTH];

	logic            accept_c;
	logic            is_read_c;
	logic            is_newline_c;
	logic            is_print_c;
	logic            room_c;
	logic            last_row_c;
	logic            range_c;
	logic            sweeping_c;
	logic            sweep_end_c;
	logic            load_c;
	logic [RW-1:0]   lrow_c;
	logic [RW:0]     rsum_c;
	logic [RW-1:0]   prow_c;
	logic [CW-1:0]   pcol_c;
	logic [AW-1:0]   addr_c;
	logic            we_c;
	logic [7:0]      wdata_c;

	assign accept_c = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign rsp.valid = rsp_valid_q;
	assign rsp.payload = rsp_q;

	// Decode of the request held for execution.
	assign is_read_c    = (item_q.action == txc_pkg::ACT_READ);
	assign is_newline_c = !is_read_c && (item_q.char_code == txc_pkg::NEWLINE_CODE);
	assign is_print_c   = !is_read_c && !is_newline_c &&
		(item_q.char_code != txc_pkg::NULL_CODE);
	assign room_c       = (col_q < CW'(COLUMNS - 1));
	assign last_row_c   = (row_q == RW'(ROWS - 1));
	assign range_c      = (32'(item_q.read_row) < ROWS) &&
		(32'(item_q.read_column) < COLUMNS);
	assign sweeping_c   = (state_q == ST_INIT) || (state_q == ST_SWEEP);
	assign sweep_end_c  = (sweep_col_q == CW'(COLUMNS - 1));
	assign load_c       = (state_q == ST_DONE) && (!rsp_valid_q || rsp.ready);

	// Shared address unit: rotate the logical row by the row base, then form
	// the linear cell address. Sweeps bypass the rotation with a physical row.
	always_comb begin
		lrow_c = is_read_c ? RW'(item_q.read_row) : row_q;
		rsum_c = {1'b0, lrow_c} + {1'b0, base_q};
		if (sweeping_c) begin
			prow_c = sweep_row_q;
			pcol_c = sweep_col_q;
		end else begin
			if (rsum_c >= (RW+1)'(ROWS)) begin
				prow_c = RW'(rsum_c - (RW+1)'(ROWS));
			end else begin
				prow_c = RW'(rsum_c);
			end
			pcol_c = is_read_c ? CW'(item_q.read_column) : col_q;
		end
		addr_c = AW'(prow_c) * AW'(COLUMNS) + AW'(pcol_c);
	end

	// Memory writes: zeros while sweeping, the character on a printable put with room.
	assign we_c    = sweeping_c || ((state_q == ST_EXEC) && is_print_c && room_c);
	assign wdata_c = sweeping_c ? 8'd0 : item_q.char_code;

	// Cell store with a registered read port.
	always_ff @(posedge clk) begin
		if (we_c) begin
			mem[addr_c] <= wdata_c;
		end
		rd_data_q <= mem[addr_c];
	end

	// Request capture and per-request result flags.
	always_ff @(posedge clk) begin
		if (accept_c) begin
			item_q <= req.payload;
		end
		if (state_q == ST_EXEC) begin
			range_q    <= range_c;
			cell_q     <= 8'd0;
			scrolled_q <= is_newline_c && last_row_c;
			dropped_q  <= is_print_c && !room_c;
		end
		if (state_q == ST_READ) begin
			cell_q <= range_q ? rd_data_q : 8'd0;
		end
		if (load_c) begin
			rsp_q.cell_char     <= cell_q;
			rsp_q.cursor_row    <= txc_pkg::ROW_W'(row_q);
			rsp_q.cursor_column <= txc_pkg::COL_W'(col_q);
			rsp_q.scrolled      <= scrolled_q;
			rsp_q.dropped       <= dropped_q;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (load_c) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Sequencer, cursor, row base and sweep counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			row_q       <= '0;
			col_q       <= '0;
			base_q      <= '0;
			sweep_row_q <= '0;
			sweep_col_q <= '0;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					if (sweep_end_c) begin
						sweep_col_q <= '0;
						if (sweep_row_q == RW'(ROWS - 1)) begin
							sweep_row_q <= '0;
							state_q     <= ST_IDLE;
						end else begin
							sweep_row_q <= sweep_row_q + 1'b1;
						end
					end else begin
						sweep_col_q <= sweep_col_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept_c) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (is_read_c) begin
						state_q <= ST_READ;
					end else if (is_newline_c) begin
						col_q <= '0;
						if (last_row_c) begin
							// The old top row becomes the new bottom row.
							sweep_row_q <= base_q;
							sweep_col_q <= '0;
							base_q      <= (base_q == RW'(ROWS - 1)) ? '0 : base_q + 1'b1;
							state_q     <= ST_SWEEP;
						end else begin
							row_q   <= row_q + 1'b1;
							state_q <= ST_DONE;
						end
					end else begin
						if (is_print_c && room_c) begin
							col_q <= col_q + 1'b1;
						end
						state_q <= ST_DONE;
					end
				end
				ST_READ: begin
					state_q <= ST_DONE;
				end
				ST_SWEEP: begin
					if (sweep_end_c) begin
						sweep_col_q <= '0;
						state_q     <= ST_DONE;
					end else begin
						sweep_col_q <= sweep_col_q + 1'b1;
					end
				end
				ST_DONE: begin
					if (load_c) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_INIT;
				end
			endcase
		end
	end

endmodule

// ----- hw/rtl/txc_checker.sv -----
// Port-level checks on the console channels.
module txc_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input txc_pkg::rsp_t rsp_payload
);

	// A stalled result keeps its value until it is taken.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
		else $error("result changed while stalled");

	// One request at a time: ready drops right after an accepted request.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request accepted while another is in progress");

	// A scroll always leaves the cursor at the start of a row.
	a_scroll_col: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_payload.scrolled |-> rsp_payload.cursor_column == '0)
		else $error("scroll with nonzero cursor column");

	// A result is never both a scroll and a drop, and either one carries a zero cell character.
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_payload.scrolled || rsp_payload.dropped) |->
			!(rsp_payload.scrolled && rsp_payload.dropped) &&
			rsp_payload.cell_char == '0)
		else $error("conflicting result flags");

endmodule

bind text_console_cell_buffer_unit txc_checker u_txc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.req_valid   (req.valid),
	.req_ready   (req.ready),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.rsp_payload (rsp.payload)
);
